FILE: hdl/csu_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore unit package
// Shared sizes, codes, state machine type and controller interface structs.
// ----------------------------------------------------------------------------
package csu_pkg;

    localparam int NUM_SEMS    = 256;
    localparam int QUEUE_DEPTH = 16;
    localparam int PID_BITS    = 16;

    localparam int ADDR_SLOTS = (NUM_SEMS < 256) ? NUM_SEMS : 256;
    localparam int SLOT_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int HEAD_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEN_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W      = 16;
    localparam int META_W     = CNT_W + HEAD_W + LEN_W;
    localparam int PID_DEPTH  = NUM_SEMS * QUEUE_DEPTH;
    localparam int PA_W       = $clog2(PID_DEPTH);
    localparam int GRP        = 16;
    localparam int GRP_LOW_W  = 4;
    localparam int NGRP       = (ADDR_SLOTS + GRP - 1) / GRP;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_WAIT   = 2'd1,
        CMD_SIGNAL = 2'd2,
        CMD_FREE   = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_BAD_ID  = 3'd2,
        ST_FULL    = 3'd3,
        ST_NEG     = 3'd4,
        ST_QFULL   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        META_NONE,
        META_CREATE,
        META_DEC,
        META_INC,
        META_PUSH,
        META_POP
    } meta_op_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_DECODE,
        FSM_RES,
        FSM_SRCH,
        FSM_META,
        FSM_VWAKE,
        FSM_FRD,
        FSM_FEMIT
    } fsm_state_t;

    typedef struct packed {
        logic      load_in;
        logic      meta_rd;
        meta_op_t  meta_op;
        logic      pid_rd;
        logic      pid_rd_iter;
        logic      pid_wr;
        logic      iter_clr;
        logic      iter_inc;
        logic      slot_set;
        logic      slot_clr;
        logic      out_load;
        status_t   out_status;
        logic      out_new;
        logic      out_had;
        logic      out_wake;
        logic      out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      neg;
        logic      bad;
        logic      found;
        logic      count_zero;
        logic      len_zero;
        logic      len_full;
        logic      iter_last;
        logic      out_free;
    } dp_stat_t;

endpackage

FILE: hdl/csu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/csu_ctrl.sv
// ----------------------------------------------------------------------------
// Counting semaphore controller
// State machine that sequences decode, slot search, state reads and wakes.
// ----------------------------------------------------------------------------
module csu_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  csu_pkg::dp_stat_t  stat,
    output csu_pkg::ctrl_cmd_t cmd
);
    import csu_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) state_next = FSM_DECODE;
            end
            FSM_DECODE: begin
                if (stat.cmd == CMD_CREATE) begin
                    state_next = stat.neg ? FSM_RES : FSM_SRCH;
                end else begin
                    state_next = stat.bad ? FSM_RES : FSM_META;
                end
            end
            FSM_RES, FSM_SRCH, FSM_VWAKE: begin
                if (stat.out_free) state_next = FSM_IDLE;
            end
            FSM_META: begin
                if (stat.cmd == CMD_SIGNAL && !stat.len_zero) begin
                    state_next = FSM_VWAKE;
                end else if (stat.cmd == CMD_FREE && !stat.len_zero) begin
                    state_next = FSM_FRD;
                end else if (stat.out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_FRD: state_next = FSM_FEMIT;
            FSM_FEMIT: begin
                if (stat.out_free) state_next = stat.iter_last ? FSM_IDLE : FSM_FRD;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.meta_op    = META_NONE;
        cmd.out_status = ST_OK;
        cmd.out_last   = 1'b1;
        s_tready       = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            FSM_DECODE: begin
                cmd.meta_rd = 1'b1;
            end
            FSM_RES: begin
                cmd.out_load   = stat.out_free;
                cmd.out_status = (stat.cmd == CMD_CREATE) ? ST_NEG : ST_BAD_ID;
            end
            FSM_SRCH: begin
                cmd.out_load = stat.out_free;
                if (stat.found) begin
                    cmd.out_new  = 1'b1;
                    cmd.slot_set = stat.out_free;
                    if (stat.out_free) cmd.meta_op = META_CREATE;
                end else begin
                    cmd.out_status = ST_FULL;
                end
            end
            FSM_META: begin
                case (stat.cmd)
                    CMD_WAIT: begin
                        cmd.out_load = stat.out_free;
                        if (!stat.count_zero) begin
                            if (stat.out_free) cmd.meta_op = META_DEC;
                        end else if (stat.len_full) begin
                            cmd.out_status = ST_QFULL;
                        end else begin
                            cmd.out_status = ST_BLOCKED;
                            cmd.pid_wr     = stat.out_free;
                            if (stat.out_free) cmd.meta_op = META_PUSH;
                        end
                    end
                    CMD_SIGNAL: begin
                        if (!stat.len_zero) begin
                            cmd.pid_rd = 1'b1;
                        end else begin
                            cmd.out_load = stat.out_free;
                            if (stat.out_free) cmd.meta_op = META_INC;
                        end
                    end
                    CMD_FREE: begin
                        if (!stat.len_zero) begin
                            cmd.iter_clr = 1'b1;
                        end else begin
                            cmd.out_load = stat.out_free;
                            cmd.slot_clr = stat.out_free;
                        end
                    end
                    default: ;
                endcase
            end
            FSM_VWAKE: begin
                cmd.out_load = stat.out_free;
                cmd.out_wake = 1'b1;
                if (stat.out_free) cmd.meta_op = META_POP;
            end
            FSM_FRD: begin
                cmd.pid_rd      = 1'b1;
                cmd.pid_rd_iter = 1'b1;
            end
            FSM_FEMIT: begin
                cmd.out_load = stat.out_free;
                cmd.out_had  = 1'b1;
                cmd.out_wake = 1'b1;
                cmd.out_last = stat.iter_last;
                cmd.iter_inc = stat.out_free;
                cmd.slot_clr = stat.out_free && stat.iter_last;
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/csu_datapath.sv
// ----------------------------------------------------------------------------
// Counting semaphore datapath
// Input word register, in-use bits with a two-stage free-slot search,
// count and queue state memory, pid queue memory and result register.
// ----------------------------------------------------------------------------
module csu_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [csu_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                     s_tuser,
    input  csu_pkg::ctrl_cmd_t             cmd,
    output csu_pkg::dp_stat_t              stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [csu_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [2:0]                     m_tuser,
    output logic                           m_tlast
);
    import csu_pkg::*;

    cmd_code_t             cmd_reg;
    logic [7:0]            sem_reg;
    logic [CNT_W-1:0]      sv_reg;
    logic [PID_BITS-1:0]   pid_reg;
    logic [NUM_SEMS-1:0]   in_use_reg;
    logic [NGRP-1:0]       grp_free_reg;
    logic [GRP_LOW_W-1:0]  grp_low_reg [NGRP];
    logic [NGRP-1:0]       grp_free;
    logic [GRP_LOW_W-1:0]  grp_low [NGRP];
    logic                  found;
    logic [SLOT_W-1:0]     new_slot;
    logic [SLOT_W-1:0]     slot_idx;
    logic                  in_range;
    logic [LEN_W-1:0]      iter_reg;

    logic [META_W-1:0]     meta_rdata;
    logic [META_W-1:0]     meta_wdata;
    logic [CNT_W-1:0]      count;
    logic [HEAD_W-1:0]     head;
    logic [LEN_W-1:0]      len;
    logic [HEAD_W-1:0]     head_inc;
    logic [LEN_W-1:0]      pos_off;
    logic [LEN_W:0]        pos_sum;
    logic [HEAD_W-1:0]     pos;
    logic [PA_W-1:0]       pid_addr;
    logic [PID_BITS-1:0]   pid_rdata;

    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic [2:0]            m_user_reg;
    logic                  m_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg <= cmd_code_t'(s_tuser);
            sem_reg <= s_tdata[7:0];
            sv_reg  <= s_tdata[23:8];
            pid_reg <= PID_BITS'(s_tdata[39:24]);
        end
    end

    assign in_range = 32'(sem_reg) < 32'(NUM_SEMS);
    assign slot_idx = SLOT_W'(sem_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else begin
            if (cmd.slot_set) in_use_reg[new_slot] <= 1'b1;
            if (cmd.slot_clr) in_use_reg[slot_idx] <= 1'b0;
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_free[g] = 1'b0;
            grp_low[g]  = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (g * GRP + j < ADDR_SLOTS) begin
                    if (!in_use_reg[g * GRP + j]) begin
                        grp_free[g] = 1'b1;
                        grp_low[g]  = GRP_LOW_W'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_free_reg <= grp_free;
        grp_low_reg  <= grp_low;
    end

    always_comb begin
        found    = 1'b0;
        new_slot = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_free_reg[g]) begin
                found    = 1'b1;
                new_slot = SLOT_W'(g * GRP + int'(grp_low_reg[g]));
            end
        end
    end

    assign {count, head, len} = meta_rdata;
    assign head_inc = (32'(head) == QUEUE_DEPTH - 1) ? '0 : HEAD_W'(head + 1'b1);

    always_comb begin
        case (cmd.meta_op)
            META_CREATE: meta_wdata = {sv_reg, {HEAD_W{1'b0}}, {LEN_W{1'b0}}};
            META_DEC:    meta_wdata = {CNT_W'(count - 1'b1), head, len};
            META_INC:    meta_wdata = {CNT_W'(count + {{(CNT_W-1){1'b0}}, ~&count}),
                                       head, len};
            META_PUSH:   meta_wdata = {count, head, LEN_W'(len + 1'b1)};
            META_POP:    meta_wdata = {count, head_inc, LEN_W'(len - 1'b1)};
            default:     meta_wdata = meta_rdata;
        endcase
    end

    csu_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_SEMS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (cmd.meta_op != META_NONE),
        .waddr (cmd.meta_op == META_CREATE ? new_slot : slot_idx),
        .wdata (meta_wdata),
        .re    (cmd.meta_rd),
        .raddr (slot_idx),
        .rdata (meta_rdata)
    );

    always_comb begin
        if (cmd.pid_wr) begin
            pos_off = len;
        end else if (cmd.pid_rd_iter) begin
            pos_off = iter_reg;
        end else begin
            pos_off = '0;
        end
        pos_sum = (LEN_W+1)'(head) + (LEN_W+1)'(pos_off);
        if (32'(pos_sum) >= QUEUE_DEPTH) begin
            pos = HEAD_W'(32'(pos_sum) - QUEUE_DEPTH);
        end else begin
            pos = HEAD_W'(pos_sum);
        end
        pid_addr = PA_W'(PA_W'(slot_idx) * PA_W'(QUEUE_DEPTH)) + PA_W'(pos);
    end

    csu_ram #(
        .WIDTH (PID_BITS),
        .DEPTH (PID_DEPTH)
    ) u_pid_ram (
        .aclk  (aclk),
        .we    (cmd.pid_wr),
        .waddr (pid_addr),
        .wdata (pid_reg),
        .re    (cmd.pid_rd),
        .raddr (pid_addr),
        .rdata (pid_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.iter_clr) begin
            iter_reg <= '0;
        end else if (cmd.iter_inc) begin
            iter_reg <= LEN_W'(iter_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_user_reg <= cmd.out_status;
            m_last_reg <= cmd.out_last;
            m_data_reg <= {6'd0,
                           cmd.out_wake ? 16'(pid_rdata) : 16'd0,
                           cmd.out_wake,
                           cmd.out_had,
                           cmd.out_new ? 8'(new_slot) : 8'd0};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign stat.cmd        = cmd_reg;
    assign stat.neg        = sv_reg[CNT_W-1];
    assign stat.bad        = !in_range || !in_use_reg[slot_idx];
    assign stat.found      = found;
    assign stat.count_zero = (count == '0);
    assign stat.len_zero   = (len == '0);
    assign stat.len_full   = (32'(len) >= QUEUE_DEPTH);
    assign stat.iter_last  = (LEN_W'(iter_reg + 1'b1) == len);
    assign stat.out_free   = !m_valid_reg || m_tready;

endmodule

FILE: hdl/counting_semaphore_unit.sv
// Flow: an accepted word is registered, the state memory read is issued in decode, and the
// result is loaded into the output register when it is free; a wake by signal and each
// wake by free add a pid memory read. A new word is taken only in idle, one at a time.
// Reset: in-use bits, controller and output valid clear at once; the count, queue state
// and pid memories are not cleared; create rewrites count and queue state before use.
// ----------------------------------------------------------------------------
// Counting semaphore unit
// Table of counting semaphores with per-slot FIFO wait queues of process ids.
// ----------------------------------------------------------------------------
module counting_semaphore_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sem_index, start_value, caller_pid
    input  logic [csu_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_index, had_waiters, wake_valid, wake_pid
    output logic [csu_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic [2:0]                    m_tuser,
    output logic                          m_tlast
);
    import csu_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    csu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    csu_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a waiting word");

    a_slot_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.slot_set && cmd.slot_clr))
        else $error("slot claimed and released together");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while one is in progress");

    a_meta_port: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.meta_op != META_NONE) |-> !cmd.meta_rd)
        else $error("state memory read and written together");
`endif

endmodule

FILE: tb/counting_semaphore_unit_tb.sv
// ----------------------------------------------------------------------------
// Counting semaphore unit testbench
// Drives create, wait, signal and free words through the stream ports. A
// scoreboard keeps its own copy of the semaphore table and wait queues and
// predicts every result word, which is then compared field by field.
// ----------------------------------------------------------------------------
module counting_semaphore_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csu_pkg::*;

    typedef struct packed {
        status_t     status;
        logic [7:0]  new_index;
        logic        had_waiters;
        logic        wake_valid;
        logic [15:0] wake_pid;
        logic        last;
    } sem_result_t;

    class sem_scoreboard;
        bit          in_use [256];
        int unsigned count [256];
        logic [15:0] waiters [256][$];
        sem_result_t pending [$];
        int          errors;
        int          words_seen;
        int          wakes_seen;

        function void push_result(status_t st, int idx, bit had, bit wv,
                                  logic [15:0] pid, bit lst);
            sem_result_t r;
            r.status = st;
            r.new_index = idx[7:0];
            r.had_waiters = had;
            r.wake_valid = wv;
            r.wake_pid = pid;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void note_command(cmd_code_t cmd, logic [7:0] idx,
                                   logic [15:0] start, logic [15:0] pid);
            int slot;
            int n;
            slot = -1;
            if (cmd == CMD_CREATE) begin
                if (start[15]) begin
                    push_result(ST_NEG, 0, 0, 0, 0, 1);
                    return;
                end
                for (int i = 0; i < 256; i++) begin
                    if (!in_use[i] && slot < 0) slot = i;
                end
                if (slot < 0) begin
                    push_result(ST_FULL, 0, 0, 0, 0, 1);
                end else begin
                    in_use[slot] = 1;
                    count[slot] = start;
                    waiters[slot].delete();
                    push_result(ST_OK, slot, 0, 0, 0, 1);
                end
                return;
            end
            if (!in_use[idx]) begin
                push_result(ST_BAD_ID, 0, 0, 0, 0, 1);
                return;
            end
            case (cmd)
                CMD_WAIT: begin
                    if (count[idx] > 0) begin
                        count[idx]--;
                        push_result(ST_OK, 0, 0, 0, 0, 1);
                    end else if (waiters[idx].size() >= QUEUE_DEPTH) begin
                        push_result(ST_QFULL, 0, 0, 0, 0, 1);
                    end else begin
                        waiters[idx].push_back(pid);
                        push_result(ST_BLOCKED, 0, 0, 0, 0, 1);
                    end
                end
                CMD_SIGNAL: begin
                    if (waiters[idx].size() > 0) begin
                        push_result(ST_OK, 0, 0, 1, waiters[idx].pop_front(), 1);
                    end else begin
                        if (count[idx] < 16'hFFFF) count[idx]++;
                        push_result(ST_OK, 0, 0, 0, 0, 1);
                    end
                end
                default: begin
                    in_use[idx] = 0;
                    count[idx] = 0;
                    n = waiters[idx].size();
                    if (n == 0) push_result(ST_OK, 0, 0, 0, 0, 1);
                    for (int i = 0; i < n; i++) begin
                        push_result(ST_OK, 0, 1, 1, waiters[idx][i], i == n - 1);
                    end
                    waiters[idx].delete();
                end
            endcase
        endfunction

        function void check_result(sem_result_t got);
            sem_result_t exp;
            words_seen++;
            if (got.wake_valid) wakes_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result word status=%0d", got.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.new_index !== exp.new_index) begin
                $error("new_index: expected %0d, actual %0d", exp.new_index, got.new_index);
                errors++;
            end
            if (got.had_waiters !== exp.had_waiters) begin
                $error("had_waiters: expected %0d, actual %0d", exp.had_waiters,
                       got.had_waiters);
                errors++;
            end
            if (got.wake_valid !== exp.wake_valid) begin
                $error("wake_valid: expected %0d, actual %0d", exp.wake_valid,
                       got.wake_valid);
                errors++;
            end
            if (got.wake_pid !== exp.wake_pid) begin
                $error("wake_pid: expected %0h, actual %0h", exp.wake_pid, got.wake_pid);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, actual %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;

    counting_semaphore_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    sem_scoreboard board;
    int            cycle_count;
    int            sent_words;
    bit            hold_off;

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        sem_result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            r.status = status_t'(m_tuser);
            r.new_index = m_tdata[7:0];
            r.had_waiters = m_tdata[8];
            r.wake_valid = m_tdata[9];
            r.wake_pid = m_tdata[25:10];
            r.last = m_tlast;
            board.check_result(r);
        end
    end

    // Receiver stalls on a random pattern, with one long hold-off.
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if (cycle_count % 300 < 100) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_word(cmd_code_t cmd, logic [7:0] idx, logic [15:0] start,
                             logic [15:0] pid);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {pid, start, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_command(cmd, idx, start, pid);
        sent_words++;
    endtask

    task automatic pause_sender();
        int gap;
        gap = $urandom_range(0, 4) == 0 ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [7:0] pick_slot();
        int tries;
        logic [7:0] s;
        s = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0) return s;
        for (tries = 0; tries < 8; tries++) begin
            s = $urandom_range(0, 7);
            if (board.in_use[s]) return s;
        end
        return s;
    endfunction

    task automatic random_word();
        int sel;
        cmd_code_t cmd;
        logic [15:0] start;
        sel = $urandom_range(0, 99);
        if (sel < 15) cmd = CMD_CREATE;
        else if (sel < 55) cmd = CMD_WAIT;
        else if (sel < 85) cmd = CMD_SIGNAL;
        else cmd = CMD_FREE;
        start = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
        send_word(cmd, pick_slot(), start, 16'($urandom));
    endtask

    initial begin
        board = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_CREATE;
        m_tready = 1'b0;
        hold_off = 1'b0;
        cycle_count = 0;
        sent_words = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(CMD_WAIT, 8'd0, 16'd0, 16'd1);
        send_word(CMD_CREATE, 8'd0, 16'h8000, 16'd0);
        send_word(CMD_CREATE, 8'd0, 16'h0000, 16'd0);
        send_word(CMD_CREATE, 8'd0, 16'h7FFF, 16'd0);
        send_word(CMD_SIGNAL, 8'd255, 16'd0, 16'd0);
        send_word(CMD_WAIT, 8'd0, 16'd0, 16'hFFFF);
        send_word(CMD_WAIT, 8'd0, 16'd0, 16'h0000);
        send_word(CMD_SIGNAL, 8'd0, 16'd0, 16'd0);
        send_word(CMD_FREE, 8'd0, 16'd0, 16'd0);
        send_word(CMD_FREE, 8'd0, 16'd0, 16'd0);
        send_word(CMD_WAIT, 8'd1, 16'd0, 16'd0);
        send_word(CMD_FREE, 8'd1, 16'd0, 16'd0);
        send_word(CMD_CREATE, 8'd0, 16'hFFFF, 16'd0);
        send_word(CMD_CREATE, 8'd0, 16'h0000, 16'd0);
        send_word(CMD_CREATE, 8'd0, 16'h7FFF, 16'd0);
        // Fill the wait queue of slot 0 past its depth, then free it.
        for (int i = 0; i < 17; i++) send_word(CMD_WAIT, 8'd0, 16'd0, 16'(i * 4099));
        send_word(CMD_FREE, 8'd0, 16'd0, 16'd0);

        for (int i = 0; i < 140; i++) begin
            if (i == 60) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (200) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_word();
            pause_sender();
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d command words; checked %0d result words, %0d of them wakes.",
                 sent_words, board.words_seen, board.wakes_seen);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: files.f
hdl/csu_pkg.sv
hdl/csu_ram.sv
hdl/csu_ctrl.sv
hdl/csu_datapath.sv
hdl/counting_semaphore_unit.sv
tb/counting_semaphore_unit_tb.sv
